// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none

module spq_cell (
    input  wire logic                             clk,
    input  wire spq_pkg::cell_ctrl_t              ctrl,
    input  wire logic                             in_use,
    input  wire logic signed [spq_pkg::DATA_W-1:0] prev_entry,
    input  wire logic                             prev_le,
    input  wire logic signed [spq_pkg::DATA_W-1:0] next_entry,
    output logic signed [spq_pkg::DATA_W-1:0]      entry,
    output logic                                  le
);

    import spq_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;

    // insert point lies at or before this cell
    assign le    = !in_use || (entry_reg <= ctrl.value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && le)
        begin
            entry_next = prev_le ? prev_entry : ctrl.value;
        end
        else if (ctrl.deq)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue of up to 16 signed 32-bit words, largest first; among
// equal words the newest leaves first. Each input word is an enqueue or a
// dequeue. One operation is accepted every cycle unless in_stall is high; its
// result is registered and shows in the cycle after acceptance; the store is a
// row of cells that all compare the incoming value against their own entry at
// once and shift by one place, so the cost of an operation does not depend on
// how full the queue is. An enqueue to a full queue or a dequeue from an empty
// one leaves the store as it was and reports the reason in status. Every
// result carries the count and the empty and full flags after the operation.
`default_nettype none

module sorted_priority_queue_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              operation,
    input  wire logic signed [spq_pkg::DATA_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]      out_value,
    output logic [1:0]                             status,
    output logic [spq_pkg::COUNT_W-1:0]            count,
    output logic                                   is_empty,
    output logic                                   is_full
);

    import spq_pkg::*;

    logic                     in_accept;
    logic                     full_now;
    logic                     empty_now;
    cell_ctrl_t               ctrl;
    logic [CAPACITY-1:0]      in_use;
    logic [CAPACITY-1:0]      cell_le;
    logic signed [DATA_W-1:0] cell_entry [CAPACITY];

    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] out_value_next;
    status_t                  out_status_reg;
    status_t                  out_status_next;
    logic [OCC_W-1:0]         out_occ_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign full_now  = (occ_reg == OCC_W'(CAPACITY));
    assign empty_now = (occ_reg == '0);

    assign ctrl.enq   = in_accept && (operation == OP_ENQUEUE) && !full_now;
    assign ctrl.deq   = in_accept && (operation == OP_DEQUEUE) && !empty_now;
    assign ctrl.value = value;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] prev_entry;
            logic                     prev_le;
            logic signed [DATA_W-1:0] next_entry;

            assign in_use[i] = (occ_reg > OCC_W'(i));

            if (i == 0)
            begin : g_head
                assign prev_entry = '0;
                assign prev_le    = 1'b0;
            end
            else
            begin : g_body
                assign prev_entry = cell_entry[i-1];
                assign prev_le    = cell_le[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign next_entry = cell_entry[i];
            end
            else
            begin : g_mid
                assign next_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .in_use     (in_use[i]),
                .prev_entry (prev_entry),
                .prev_le    (prev_le),
                .next_entry (next_entry),
                .entry      (cell_entry[i]),
                .le         (cell_le[i])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next        = occ_reg;
        out_value_next  = '0;
        out_status_next = STATUS_OK;
        if (operation == OP_ENQUEUE)
        begin
            if (full_now)
            begin
                out_status_next = STATUS_FULL;
            end
            else
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
        end
        else
        begin
            if (empty_now)
            begin
                out_status_next = STATUS_EMPTY;
            end
            else
            begin
                occ_next       = occ_reg - OCC_W'(1);
                out_value_next = cell_entry[0];
            end
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= occ_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = out_status_reg;
    assign count     = COUNT_W'(out_occ_reg);
    assign is_empty  = (out_occ_reg == '0);
    assign is_full   = (out_occ_reg == OCC_W'(CAPACITY));

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
    else $error("occupancy beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |=> occ_reg == $past(occ_reg) + OCC_W'(1))
    else $error("enqueue did not grow occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (operation == OP_DEQUEUE) && empty_now
        |=> out_status_reg == STATUS_EMPTY && occ_reg == '0)
    else $error("empty dequeue not rejected");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (operation == OP_ENQUEUE) && full_now
        |=> out_status_reg == STATUS_FULL && $stable(occ_reg))
    else $error("full enqueue not rejected");

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg >= OCC_W'(2) |-> cell_entry[0] >= cell_entry[1])
    else $error("head entries out of order");

endmodule

`default_nettype wire
